/* hdl/fpalu_pkg.sv */
// Package for the fixed-point ALU: opcodes, widths and pipeline depth.
// No dependencies.
package fpalu_pkg;
	localparam int FracBits = 8;
	localparam int DataW    = 32;
	localparam int QuotW    = DataW + FracBits;
	localparam int DivDepth = QuotW;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DIV  = 4'd3;
	localparam logic [3:0] OP_MAX  = 4'd4;
	localparam logic [3:0] OP_INC  = 4'd5;
	localparam logic [3:0] OP_DEC  = 4'd6;
	localparam logic [3:0] OP_TOI  = 4'd7;
	localparam logic [3:0] OP_FROMI = 4'd8;

	typedef struct packed {
		logic       vld;
		logic [3:0] op;
		logic       gt;
		logic       lt;
		logic       eq;
		logic       neg;
		logic       dz;
		logic [DataW-1:0] simple;
		logic       simple_sat;
	} ctl_t;
endpackage

/* hdl/fpalu_div.sv */
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on fpalu_pkg.
module fpalu_div (
	input  logic clk,
	input  logic arst_n,
	input  logic vin,
	input  logic [fpalu_pkg::QuotW-1:0] num,
	input  logic [fpalu_pkg::DataW-1:0] den,
	output logic [fpalu_pkg::QuotW-1:0] quo,
	output logic rnd_up
);
	localparam int QW = fpalu_pkg::QuotW;
	localparam int DW = fpalu_pkg::DataW;
	localparam int N  = fpalu_pkg::DivDepth;

	logic [QW-1:0] n_s [N+1];
	logic [DW:0]   r_s [N+1];
	logic [DW-1:0] d_s [N+1];
	logic          v_s [N+1];

	assign n_s[0] = num;
	assign r_s[0] = '0;
	assign d_s[0] = den;
	assign v_s[0] = vin;

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [DW+1:0] tr;
		logic [DW+1:0] df;
		always_comb begin
			tr = {r_s[i], n_s[i][QW-1]};
			df = tr - {2'b00, d_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			d_s[i+1] <= d_s[i];
			if (!df[DW+1]) begin
				r_s[i+1] <= df[DW:0];
				n_s[i+1] <= {n_s[i][QW-2:0], 1'b1};
			end else begin
				r_s[i+1] <= tr[DW:0];
				n_s[i+1] <= {n_s[i][QW-2:0], 1'b0};
			end
		end
	end

	assign quo = n_s[N];
	// Round up when twice the remainder reaches the divisor.
	assign rnd_up = ({r_s[N], 1'b0} >= {2'b00, d_s[N]}) && v_s[N];
endmodule

/* hdl/fixed_point_alu_core.sv */
// Fixed-point ALU, signed Q(32-FracBits).FracBits, one result per request.
// Every opcode passes through the operand stage, the divider stages with the control delay line,
// the rounding stage and the output register; throughput one beat per cycle, set by the
// one-bit-per-stage divider pipeline. busy stays low.
// Reset clears the valid bits and control words; the receiver cannot stall, so nothing backs up.
// Depends on fpalu_pkg and fpalu_div.
module fixed_point_alu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        done,
	output logic signed [31:0] result_value,
	output logic        a_greater,
	output logic        a_less,
	output logic        a_equal,
	output logic        divide_by_zero,
	output logic        saturated
);
	localparam int DW = fpalu_pkg::DataW;
	localparam int FB = fpalu_pkg::FracBits;
	localparam int QW = fpalu_pkg::QuotW;
	localparam int N  = fpalu_pkg::DivDepth;
	localparam logic signed [65:0] SMax = 66'sd2147483647;
	localparam logic signed [65:0] SMin = -66'sd2147483648;

	// Pipeline never stalls: results cannot be held off downstream.
	assign busy = 1'b0;

	// Stage 1: operand conditioning, simple ops, comparisons.
	fpalu_pkg::ctl_t c_s1;
	logic signed [DW-1:0] a_s1, b_s1;
	logic [QW-1:0] num_s1;
	logic [DW-1:0] den_s1;

	logic signed [33:0] sum_w;
	logic [DW-1:0] simple_w;
	logic sat_w;
	logic [DW-1:0] mag_a, mag_b;
	logic signed [DW+FB:0] from_w;

	always_comb begin
		mag_a = operand_a[DW-1] ? DW'(-operand_a) : operand_a;
		mag_b = operand_b[DW-1] ? DW'(-operand_b) : operand_b;
		from_w = (DW+FB+1)'(operand_a) <<< FB;
		sum_w = '0;
		simple_w = '0;
		sat_w = 1'b0;
		case (req_type) inside
			fpalu_pkg::OP_ADD, fpalu_pkg::OP_SUB,
			fpalu_pkg::OP_INC, fpalu_pkg::OP_DEC: begin
				case (req_type)
					fpalu_pkg::OP_ADD: sum_w = 34'(operand_a) + 34'(operand_b);
					fpalu_pkg::OP_SUB: sum_w = 34'(operand_a) - 34'(operand_b);
					fpalu_pkg::OP_INC: sum_w = 34'(operand_a) + 34'sd1;
					default:           sum_w = 34'(operand_a) - 34'sd1;
				endcase
				if (sum_w > 34'sd2147483647) begin
					simple_w = 32'h7fffffff; sat_w = 1'b1;
				end else if (sum_w < -34'sd2147483648) begin
					simple_w = 32'h80000000; sat_w = 1'b1;
				end else begin
					simple_w = sum_w[DW-1:0];
				end
			end
			fpalu_pkg::OP_MAX:
				simple_w = (operand_a >= operand_b) ? operand_a : operand_b;
			fpalu_pkg::OP_TOI:
				simple_w = DW'(operand_a >>> FB);
			fpalu_pkg::OP_FROMI: begin
				if (from_w > (DW+FB+1)'(SMax)) begin
					simple_w = 32'h7fffffff; sat_w = 1'b1;
				end else if (from_w < (DW+FB+1)'(SMin)) begin
					simple_w = 32'h80000000; sat_w = 1'b1;
				end else begin
					simple_w = from_w[DW-1:0];
				end
			end
			default: simple_w = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
		end else begin
			c_s1.vld <= start;
			c_s1.op <= req_type;
			c_s1.gt <= operand_a > operand_b;
			c_s1.lt <= operand_a < operand_b;
			c_s1.eq <= operand_a == operand_b;
			c_s1.neg <= operand_a[DW-1] ^ operand_b[DW-1];
			c_s1.dz <= (req_type == fpalu_pkg::OP_DIV) && (operand_b == '0);
			c_s1.simple <= simple_w;
			c_s1.simple_sat <= sat_w;
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= operand_a;
		b_s1 <= operand_b;
		num_s1 <= QW'(mag_a) << FB;
		den_s1 <= mag_b;
	end

	// Divider runs every beat; its answer is used only for divide.
	logic [QW-1:0] quo;
	logic rnd_up;
	fpalu_div u_div (
		.clk(clk), .arst_n(arst_n), .vin(c_s1.vld),
		.num(num_s1), .den(den_s1), .quo(quo), .rnd_up(rnd_up)
	);

	// Multiplier: register product, carry it along the delay line, then round in the rounding stage.
	logic signed [63:0] prod_s2;
	logic signed [63:0] prod_d [N];
	always_ff @(posedge clk) begin
		prod_s2 <= 64'(a_s1) * 64'(b_s1);
	end

	// Delay line keeps control beside the divider stages.
	fpalu_pkg::ctl_t c_d [N+1];
	assign c_d[0] = c_s1;
	assign prod_d[0] = prod_s2;
	for (genvar i = 0; i < N; i++) begin : g_dl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_d[i+1] <= '0;
			end else begin
				c_d[i+1] <= c_d[i];
			end
		end
		if (i < N-1) begin : g_pd
			always_ff @(posedge clk) prod_d[i+1] <= prod_d[i];
		end
	end

	// Stage N+2: round magnitudes to signed values.
	fpalu_pkg::ctl_t c_s3;
	logic signed [65:0] div_s3, mul_s3;
	logic [63:0] pm_w;
	logic [63:0] pr_w;
	always_comb begin
		pm_w = prod_d[N-1][63] ? 64'(-prod_d[N-1]) : prod_d[N-1];
		pr_w = (pm_w + (64'd1 << (FB-1))) >> FB;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s3 <= '0;
		end else begin
			c_s3 <= c_d[N];
		end
	end
	always_ff @(posedge clk) begin
		div_s3 <= c_d[N].neg ? -(66'(quo) + 66'(rnd_up)) : 66'(quo) + 66'(rnd_up);
		mul_s3 <= prod_d[N-1][63] ? -66'(pr_w) : 66'(pr_w);
	end

	// Final stage: select, clamp and present the beat for one cycle.
	logic signed [65:0] pick_w;
	logic [DW-1:0] res_w;
	logic rs_w;
	always_comb begin
		pick_w = (c_s3.op == fpalu_pkg::OP_MUL) ? mul_s3 : div_s3;
		res_w = c_s3.simple;
		rs_w = c_s3.simple_sat;
		if ((c_s3.op == fpalu_pkg::OP_MUL) ||
		    (c_s3.op == fpalu_pkg::OP_DIV && !c_s3.dz)) begin
			if (pick_w > SMax) begin
				res_w = 32'h7fffffff; rs_w = 1'b1;
			end else if (pick_w < SMin) begin
				res_w = 32'h80000000; rs_w = 1'b1;
			end else begin
				res_w = pick_w[DW-1:0]; rs_w = 1'b0;
			end
		end else if (c_s3.op == fpalu_pkg::OP_DIV) begin
			res_w = '0; rs_w = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= c_s3.vld;
		end
	end
	always_ff @(posedge clk) begin
		result_value <= res_w;
		a_greater <= c_s3.gt;
		a_less <= c_s3.lt;
		a_equal <= c_s3.eq;
		divide_by_zero <= c_s3.dz;
		saturated <= rs_w;
	end
endmodule
